// File: rtl/awo_pkg.sv
// ----------------------------------------------------------------------------
// awo_pkg
// Shared widths, codes and types of the additive wavetable oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package awo_pkg;

  localparam int TABLE_DEPTH_DEF    = 2048;
  localparam int HARMONIC_COUNT_DEF = 8;

  localparam int GAIN_REGS  = 8;
  localparam int GAIN_W     = 16;
  localparam int SINE_W     = 19;
  localparam int WORD_W     = 24;
  localparam int INDEX_W    = 11;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int TERM_SHIFT = 14;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic {
    CMD_BUILD = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_ACK    = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic signed [SINE_W-1:0] sine_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } build_stat_t;

endpackage

`default_nettype wire

// File: rtl/awo_sine_rom.sv
// ----------------------------------------------------------------------------
// awo_sine_rom
// Sine ROM of TABLE_DEPTH-1 Q1.17 words, contents fixed at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

module awo_sine_rom #(
  parameter int TABLE_DEPTH = awo_pkg::TABLE_DEPTH_DEF,
  localparam int M = TABLE_DEPTH - 1,
  localparam int RAW = $clog2(M)
) (
  input  logic                clk_i,
  input  logic [RAW-1:0]      addr_i,
  output awo_pkg::sine_t      data_o
);
  import awo_pkg::*;

  localparam logic [63:0] M64 = 64'(M);

  typedef sine_t rom_t [M];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] q;
    logic [63:0] d;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] mag;
    longint      sum;
    for (int k = 0; k < M; k++) begin
      q    = 64'(4 * k);
      d    = q / M64;
      r    = q - d * M64;
      u    = d[0] ? (M64 - r) : r;
      x    = (u * HALF_PI_Q30 + M64 / 2) / M64;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
        sum = longint'(1) << 30;
      end
      mag = (64'(sum) + 64'd4096) >> 13;
      if (mag > 64'd131072) begin
        mag = 64'd131072;
      end
      rom[k] = (d >= 64'd2) ? -sine_t'(mag) : sine_t'(mag);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  sine_t data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SINE_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: rtl/awo_table_ram.sv
// ----------------------------------------------------------------------------
// awo_table_ram
// Wave table RAM: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module awo_table_ram #(
  parameter int TABLE_DEPTH = awo_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  awo_pkg::word_t      wr_data_i,
  input  logic [AW-1:0]       rd_addr_a_i,
  input  logic [AW-1:0]       rd_addr_b_i,
  output awo_pkg::word_t      rd_data_a_o,
  output awo_pkg::word_t      rd_data_b_o
);
  import awo_pkg::*;

  word_t mem [TABLE_DEPTH];
  word_t rd_a_q;
  word_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem[rd_addr_a_i];
    rd_b_q <= mem[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

`default_nettype wire

// File: rtl/awo_builder.sv
// ----------------------------------------------------------------------------
// awo_builder
// Table build sequencer: one harmonic term per cycle through the sine ROM,
// a registered multiplier and an accumulator that writes each table word.
// ----------------------------------------------------------------------------
`default_nettype none

module awo_builder #(
  parameter int TABLE_DEPTH    = awo_pkg::TABLE_DEPTH_DEF,
  parameter int HARMONIC_COUNT = awo_pkg::HARMONIC_COUNT_DEF,
  localparam int AW  = $clog2(TABLE_DEPTH),
  localparam int RAW = $clog2(TABLE_DEPTH - 1),
  localparam int HW  = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  awo_pkg::gain_t         gains_i [awo_pkg::GAIN_REGS],
  output logic [RAW-1:0]         rom_addr_o,
  input  awo_pkg::sine_t         rom_data_i,
  output logic                   wr_en_o,
  output logic [AW-1:0]          wr_addr_o,
  output awo_pkg::word_t         wr_data_o,
  output awo_pkg::build_stat_t   stat_o
);
  import awo_pkg::*;

  localparam int PROD_W = GAIN_W + SINE_W;
  localparam int TERM_W = PROD_W - TERM_SHIFT;
  localparam logic [HW-1:0] LAST_H = HW'(HARMONIC_COUNT - 1);
  localparam logic [AW-1:0] LAST_I = AW'(TABLE_DEPTH - 1);
  localparam logic [RAW+3:0] M_EXT = (RAW + 4)'(TABLE_DEPTH - 1);

  logic                       active_q;
  logic [HW-1:0]              h_q;
  logic [AW-1:0]              i_q;
  logic [RAW-1:0]             k_q [HARMONIC_COUNT];
  logic                       v1_q;
  logic [HW-1:0]              h1_q;
  logic [AW-1:0]              i1_q;
  logic                       v2_q;
  logic [HW-1:0]              h2_q;
  logic [AW-1:0]              i2_q;
  logic signed [PROD_W-1:0]   prod_q;
  word_t                      acc_q;
  logic                       done_q;
  logic [RAW+3:0]             k_sum;
  logic [RAW-1:0]             k_next;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [PROD_W-1:0]   prod_rnd;
  word_t                      term;
  word_t                      acc_d;

  assign rom_addr_o = k_q[h_q];
  assign k_sum  = (RAW + 4)'(k_q[h_q]) + (RAW + 4)'(h_q) + (RAW + 4)'(1);
  assign k_next = (k_sum >= M_EXT) ? RAW'(k_sum - M_EXT) : RAW'(k_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      h_q      <= '0;
      i_q      <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      done_q   <= 1'b0;
      for (int n = 0; n < HARMONIC_COUNT; n++) begin
        k_q[n] <= '0;
      end
    end else begin
      v1_q   <= active_q;
      v2_q   <= v1_q;
      done_q <= wr_en_o && (i2_q == LAST_I);
      if (start_i) begin
        active_q <= 1'b1;
        h_q      <= '0;
        i_q      <= '0;
        for (int n = 0; n < HARMONIC_COUNT; n++) begin
          k_q[n] <= '0;
        end
      end else if (active_q) begin
        k_q[h_q] <= k_next;
        if (h_q == LAST_H) begin
          h_q <= '0;
          i_q <= i_q + AW'(1);
          if (i_q == LAST_I) begin
            active_q <= 1'b0;
          end
        end else begin
          h_q <= h_q + HW'(1);
        end
      end
    end
  end

  assign prod_full = gains_i[h1_q] * rom_data_i;

  always_ff @(posedge clk_i) begin
    h1_q   <= h_q;
    i1_q   <= i_q;
    h2_q   <= h1_q;
    i2_q   <= i1_q;
    prod_q <= prod_full;
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  assign prod_rnd = prod_q + PROD_W'(1 << (TERM_SHIFT - 1));
  assign term     = WORD_W'($signed(prod_rnd[PROD_W-1:TERM_SHIFT]));
  assign acc_d    = ((h2_q == '0) ? word_t'(0) : acc_q) + term;

  assign wr_en_o   = v2_q && (h2_q == LAST_H);
  assign wr_addr_o = i2_q;
  assign wr_data_o = acc_d;

  assign stat_o.busy = active_q | v1_q | v2_q | done_q;
  assign stat_o.done = done_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !stat_o.busy)
    else $error("build started while a build is in progress");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(wr_en_o) && $past(i2_q) == LAST_I)
    else $error("build done without a write of the last table word");

  a_write_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> $past(v1_q) && $past(h1_q) == LAST_H)
    else $error("table write without a full harmonic sum");
`endif

endmodule

`default_nettype wire

// File: rtl/additive_wavetable_oscillator_unit.sv
// ----------------------------------------------------------------------------
// additive_wavetable_oscillator_unit
// Additive wavetable oscillator with a table RAM built from harmonic gains
// and linearly interpolated reads.
// ----------------------------------------------------------------------------
// A read is taken in any cycle in which busy_o is low; its sample is strobed
// by the output register after the RAM read and product registers; reads
// sustain one per cycle on both table RAM read ports while busy_o is low.
// A build holds busy_o high while it runs, one harmonic term per cycle
// through the sine ROM and the multiplier, and its acknowledgment is strobed
// in the first cycle in which busy_o is low again.
// Reset clears the gains and marks the table empty; reads then return zero.
// ----------------------------------------------------------------------------
`default_nettype none

module additive_wavetable_oscillator_unit #(
  parameter int TABLE_DEPTH    = awo_pkg::TABLE_DEPTH_DEF,
  parameter int HARMONIC_COUNT = awo_pkg::HARMONIC_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             command_i,
  input  logic [awo_pkg::INDEX_W-1:0]      index_int_i,
  input  logic [awo_pkg::FRAC_W-1:0]       index_frac_i,
  output logic                             result_valid_o,
  output logic                             kind_o,
  output logic signed [awo_pkg::WORD_W-1:0] sample_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [awo_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [awo_pkg::GAIN_W-1:0]       cfg_data_i
);
  import awo_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int RAW = $clog2(TABLE_DEPTH - 1);
  localparam int MUL_W = WORD_W + FRAC_W + 2;
  localparam logic [AW-1:0] LAST_I = AW'(TABLE_DEPTH - 1);

  gain_t          gain_q [GAIN_REGS];
  logic           table_ready_q;
  logic           accept;
  logic           build_start;
  logic           read_start;
  build_stat_t    bstat;
  logic [RAW-1:0] rom_addr;
  sine_t          rom_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  word_t          wr_data;
  logic [AW-1:0]  rd_lo;
  logic [AW-1:0]  rd_hi;
  word_t          lo_data;
  word_t          hi_data;

  logic                     rd_v1_q;
  logic                     rd_ok1_q;
  logic [FRAC_W-1:0]        frac1_q;
  logic                     rd_v2_q;
  logic                     rd_ok2_q;
  logic signed [MUL_W-1:0]  p_lo_full;
  logic signed [MUL_W-1:0]  p_hi_full;
  logic signed [MUL_W-1:0]  p_lo_q;
  logic signed [MUL_W-1:0]  p_hi_q;
  logic signed [MUL_W:0]    p_sum;
  logic [FRAC_W:0]          w_lo;

  logic                     result_valid_q;
  kind_e                    kind_q;
  word_t                    sample_q;

  assign busy_o      = bstat.busy;
  assign accept      = start_i && !busy_o;
  assign build_start = accept && (command_i == CMD_BUILD);
  assign read_start  = accept && (command_i == CMD_READ);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < GAIN_REGS; n++) begin
        gain_q[n] <= '0;
      end
      table_ready_q  <= 1'b0;
      rd_v1_q        <= 1'b0;
      rd_v2_q        <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        gain_q[cfg_index_i] <= gain_t'(cfg_data_i);
      end
      if (bstat.done) begin
        table_ready_q <= 1'b1;
      end
      rd_v1_q        <= read_start;
      rd_v2_q        <= rd_v1_q;
      result_valid_q <= rd_v2_q | bstat.done;
    end
  end

  awo_sine_rom #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  awo_builder #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .HARMONIC_COUNT (HARMONIC_COUNT)
  ) u_builder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (build_start),
    .gains_i    (gain_q),
    .rom_addr_o (rom_addr),
    .rom_data_i (rom_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .stat_o     (bstat)
  );

  always_comb begin
    if (32'(index_int_i) >= 32'(TABLE_DEPTH)) begin
      rd_lo = LAST_I;
    end else begin
      rd_lo = AW'(index_int_i);
    end
    rd_hi = (rd_lo == LAST_I) ? '0 : rd_lo + AW'(1);
  end

  awo_table_ram #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_lo),
    .rd_addr_b_i (rd_hi),
    .rd_data_a_o (lo_data),
    .rd_data_b_o (hi_data)
  );

  assign w_lo  = (FRAC_W + 1)'(1 << FRAC_W) - (FRAC_W + 1)'(frac1_q);
  assign p_sum = (MUL_W + 1)'(p_lo_q) + (MUL_W + 1)'(p_hi_q)
               + (MUL_W + 1)'(1 << (FRAC_W - 1));

  assign p_lo_full = lo_data * $signed({1'b0, w_lo});
  assign p_hi_full = hi_data * $signed({2'b00, frac1_q});

  always_ff @(posedge clk_i) begin
    rd_ok1_q <= table_ready_q;
    frac1_q  <= index_frac_i;
    rd_ok2_q <= rd_ok1_q;
    p_lo_q   <= p_lo_full;
    p_hi_q   <= p_hi_full;
    if (rd_v2_q) begin
      kind_q   <= KIND_SAMPLE;
      sample_q <= rd_ok2_q ? word_t'(p_sum[WORD_W+FRAC_W-1:FRAC_W]) : word_t'(0);
    end else begin
      kind_q   <= KIND_ACK;
      sample_q <= '0;
    end
  end

  assign result_valid_o = result_valid_q;
  assign kind_o         = kind_q;
  assign sample_o       = sample_q;

`ifndef NO_ASSERTIONS
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> $past(rd_v2_q) || $past(bstat.done))
    else $error("result strobe without a finished read or build");

  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_v2_q && bstat.done))
    else $error("read result and build acknowledgment in the same cycle");

  a_no_read_in_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v1_q |-> !wr_en)
    else $error("table read overlaps a table write");
`endif

endmodule

`default_nettype wire

// File: test/additive_wavetable_oscillator_unit_tb.sv
// ----------------------------------------------------------------------------
// additive_wavetable_oscillator_unit_tb
// Self-checking testbench for the additive wavetable oscillator. It programs
// the harmonic gains and issues build and read commands with random gaps.
// A scoreboard keeps its own sine ROM, gains and table, and predicts the
// acknowledgment or interpolated sample of each accepted command. It then
// compares every strobed result, in order, against that prediction.
// ----------------------------------------------------------------------------

module additive_wavetable_oscillator_unit_tb;
  import awo_pkg::*;

  localparam int DEPTH           = TABLE_DEPTH_DEF;
  localparam int HARMONICS       = HARMONIC_COUNT_DEF;
  localparam int MAX_REPORTS     = 10;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct {
    kind_e kind;
    word_t sample;
  } osc_result_t;

  class sample_scoreboard;
    sine_t       sine_rom[DEPTH-1];
    word_t       wave_table[DEPTH];
    bit          table_ready;
    gain_t       gains[GAIN_REGS];
    osc_result_t expected_results[$];
    int          mismatches;

    function new();
      foreach (gains[i]) gains[i] = '0;
      foreach (wave_table[i]) wave_table[i] = '0;
      table_ready = 1'b0;
      mismatches  = 0;
      fill_sine_rom();
    endfunction

    function longint unsigned quarter_sine(longint unsigned u, longint unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (u * HALF_PI_Q30 + m / 2) / m;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int unsigned n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum -= longint'(term);
        end else begin
          sum += longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      return longint'(sum);
    endfunction

    function void fill_sine_rom();
      longint unsigned m;
      longint unsigned q;
      longint unsigned d;
      longint unsigned r;
      longint unsigned u;
      longint unsigned mag;
      m = DEPTH - 1;
      for (longint unsigned k = 0; k < m; k++) begin
        q   = 4 * k;
        d   = q / m;
        r   = q - d * m;
        u   = d[0] ? (m - r) : r;
        mag = (quarter_sine(u, m) + 4096) >> 13;
        if (mag > 131072) mag = 131072;
        sine_rom[k] = (d >= 2) ? -sine_t'(mag) : sine_t'(mag);
      end
    endfunction

    function void rebuild_table();
      int unsigned k;
      longint      acc;
      longint      prod;
      for (int unsigned i = 0; i < DEPTH; i++) begin
        acc = 0;
        for (int unsigned h = 1; h <= HARMONICS && h <= GAIN_REGS; h++) begin
          k    = (h * i) % (DEPTH - 1);
          prod = longint'(gains[h-1]) * longint'(sine_rom[k]);
          acc += (prod + (longint'(1) << (TERM_SHIFT - 1))) >>> TERM_SHIFT;
        end
        wave_table[i] = word_t'(acc);
      end
      table_ready = 1'b1;
    endfunction

    function word_t interpolate(int unsigned idx, int unsigned frac);
      int unsigned lo;
      int unsigned hi;
      longint      acc;
      lo = (idx >= DEPTH) ? DEPTH - 1 : idx;
      hi = lo + 1;
      if (hi >= DEPTH) hi = 0;
      acc = longint'(wave_table[lo]) * (256 - longint'(frac))
          + longint'(wave_table[hi]) * longint'(frac);
      return word_t'((acc + 128) >>> 8);
    endfunction

    function void set_gain(int unsigned idx, gain_t value);
      gains[idx] = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_command(cmd_e cmd, logic [INDEX_W-1:0] idx,
                               logic [FRAC_W-1:0] frac);
      osc_result_t r;
      if (cmd == CMD_BUILD) begin
        rebuild_table();
        r.kind   = KIND_ACK;
        r.sample = '0;
      end else begin
        r.kind   = KIND_SAMPLE;
        r.sample = table_ready ? interpolate(idx, frac) : '0;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic kind, logic [WORD_W-1:0] sample);
      osc_result_t r;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: kind %0d sample %0d", kind, $signed(sample));
        end
      end else begin
        r = expected_results.pop_front();
        if (kind !== r.kind || sample !== r.sample) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result mismatch: expected kind %0d sample %0d, got kind %0d sample %0d",
                     r.kind, r.sample, kind, $signed(sample));
          end
        end
      end
    endfunction
  endclass

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start_i      = 1'b0;
  logic                  command_i    = 1'b0;
  logic [INDEX_W-1:0]    index_int_i  = '0;
  logic [FRAC_W-1:0]     index_frac_i = '0;
  logic                  cfg_valid_i  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [GAIN_W-1:0]     cfg_data_i   = '0;
  logic                  busy_o;
  logic                  result_valid_o;
  logic                  kind_o;
  logic signed [WORD_W-1:0] sample_o;
  logic                  cfg_ready_o;
  int                    cycles       = 0;

  sample_scoreboard sb = new();

  additive_wavetable_oscillator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .index_int_i    (index_int_i),
    .index_frac_i   (index_frac_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .sample_o       (sample_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("additive_wavetable_oscillator_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(kind_o, sample_o);
      if (start_i && !busy_o) sb.note_command(cmd_e'(command_i), index_int_i, index_frac_i);
    end
  end

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned random_index();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return DEPTH - 1;
      2: return DEPTH - 2;
      default: return $urandom_range(0, DEPTH - 1);
    endcase
  endfunction

  function automatic int unsigned random_frac();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic send_command(cmd_e cmd, int unsigned idx, int unsigned frac,
                              int unsigned gap);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    command_i    <= cmd;
    index_int_i  <= idx[INDEX_W-1:0];
    index_frac_i <= frac[FRAC_W-1:0];
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic program_gains(input gain_t g [GAIN_REGS]);
    for (int unsigned i = 0; i < GAIN_REGS; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[CFG_IDX_W-1:0];
      cfg_data_i  <= g[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_gain(i, g[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    gain_t       g[GAIN_REGS];
    int unsigned nharm;
    int unsigned gap;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads before the first build return zero.
    send_command(CMD_READ, 0, 0, 0);
    send_command(CMD_READ, DEPTH - 1, 255, 2);
    wait_drained();

    g = '{32767, -12000, 8000, -4000, 2000, -1000, 500, -250};
    program_gains(g);
    send_command(CMD_BUILD, 0, 0, 0);
    send_command(CMD_READ, 0, 0, 0);
    send_command(CMD_READ, 0, 255, 0);
    send_command(CMD_READ, DEPTH - 1, 0, 0);
    send_command(CMD_READ, DEPTH - 1, 255, 0);
    send_command(CMD_READ, DEPTH - 1, 128, 1);
    send_command(CMD_READ, DEPTH - 2, 128, 0);
    send_command(CMD_READ, 1, 1, 0);
    send_command(CMD_READ, 1023, 128, 5);
    wait_drained();

    // New gains leave the table untouched until the next build.
    g = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    program_gains(g);
    send_command(CMD_READ, DEPTH - 1, 255, 0);
    send_command(CMD_READ, 511, 64, 0);
    send_command(CMD_BUILD, 0, 0, 0);
    send_command(CMD_READ, 511, 64, 0);
    send_command(CMD_READ, DEPTH - 1, 255, 0);
    wait_drained();

    g = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    program_gains(g);
    send_command(CMD_BUILD, 0, 0, 0);
    send_command(CMD_READ, 0, 0, 0);
    send_command(CMD_READ, 255, 255, 0);
    send_command(CMD_READ, 1535, 128, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      nharm = $urandom_range(1, GAIN_REGS);
      for (int unsigned h = 0; h < GAIN_REGS; h++) begin
        case (p)
          1: g[h] = 16'sh7fff;
          4: g[h] = 16'sh8000;
          7: g[h] = '0;
          default: g[h] = (h < nharm) ? gain_t'($urandom_range(0, 65535)) : '0;
        endcase
      end
      program_gains(g);
      if (p != 5) send_command(CMD_BUILD, 0, 0, random_gap());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        gap = (n >= 40 && n < 70) ? 0 : random_gap();
        if ($urandom_range(0, 99) == 0) begin
          send_command(CMD_BUILD, random_index(), random_frac(), gap);
        end else begin
          send_command(CMD_READ, random_index(), random_frac(), gap);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("additive_wavetable_oscillator_unit test passed");
    end else begin
      $display("additive_wavetable_oscillator_unit test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/awo_pkg.sv
rtl/awo_sine_rom.sv
rtl/awo_table_ram.sv
rtl/awo_builder.sv
rtl/additive_wavetable_oscillator_unit.sv
test/additive_wavetable_oscillator_unit_tb.sv
